[rtl/assert_macros.svh]
// Assertion macros shared by the deframer RTL.
// Clocked on clk and disabled while rst_n is low; define NO_ASSERTIONS to drop them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication
`define ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication
`define ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_IMP(label, ante, cons, msg)
`define ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

[rtl/bfd_pkg.sv]
// Package for the bus frame deframer: parse phases, sequencer states,
// status codes and default sizes. No dependencies.
package bfd_pkg;

  // Default largest body held in the body store
  localparam int MAX_BODY_DEF = 32;

  // Result status codes
  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_CSUM = 2'd1;
  localparam logic [1:0] STAT_LEN  = 2'd2;

  // Frame parse phase
  typedef enum logic [2:0] {
    PH_SRC,
    PH_LEN,
    PH_DST,
    PH_BODY,
    PH_CHK,
    PH_DISCARD
  } phase_t;

  // Request sequencer: receiving, or replaying the body store
  typedef enum logic [1:0] {
    ST_RUN,
    ST_RD,
    ST_OUT
  } ctl_t;

endpackage

[rtl/bfd_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module bfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, held between reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/bus_frame_deframer_xor_check_unit.sv]
// Bus frame deframer with XOR checksum. Uses bfd_pkg and bfd_ram.
// Timing: an error or empty-body result appears in the cycle after its length or checksum
// byte is taken; the first byte of a good body passes a RAM read state, then an output load.
// Throughput: one received byte per cycle while a frame is coming in and in_stall is low; a
// good frame's body then replays from the body RAM (RAM read, output load per byte).
// Reset (synchronous, rst_n low): parser expects a source address, held fields clear.
module bus_frame_deframer_xor_check_unit
  import bfd_pkg::*;
#(
  parameter int MAX_BODY = MAX_BODY_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  input  logic       in_chunk_start,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_status,
  output logic [7:0] out_source_addr,
  output logic [7:0] out_dest_addr,
  output logic [5:0] out_body_length,
  output logic [7:0] out_body_byte,
  output logic [4:0] out_byte_index,
  output logic       out_last
);

  `include "assert_macros.svh"

  localparam int AW    = (MAX_BODY > 1) ? $clog2(MAX_BODY) : 1;
  localparam int LEN_W = $clog2(MAX_BODY + 1);

  // control state
  phase_t             phase_r, phase_nxt;
  ctl_t               ctl_r, ctl_nxt;
  logic [7:0]         src_r, src_nxt;
  logic [7:0]         dst_r, dst_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic [LEN_W-1:0]   cnt_r, cnt_nxt;
  logic [LEN_W-1:0]   idx_r, idx_nxt;
  logic [7:0]         xor_r, xor_nxt;
  logic               out_valid_r, out_valid_nxt;

  // output payload
  logic [1:0]         out_status_r, out_status_nxt;
  logic [7:0]         out_src_r, out_src_nxt;
  logic [7:0]         out_dst_r, out_dst_nxt;
  logic [5:0]         out_len_r, out_len_nxt;
  logic [7:0]         out_byte_r, out_byte_nxt;
  logic [4:0]         out_idx_r, out_idx_nxt;
  logic               out_last_r, out_last_nxt;

  logic               in_acc;
  logic               out_free;
  logic               out_load;
  phase_t             ph_eff;
  logic [8:0]         len_diff;
  logic               len_err;
  logic [LEN_W-1:0]   cnt_inc;
  logic [LEN_W-1:0]   idx_inc;
  logic               emit_last;
  logic [LEN_W+5:0]   len_ext;
  logic [LEN_W+4:0]   idx_ext;
  logic               ram_wr_en;
  logic               ram_rd_en;
  logic [7:0]         ram_rd_data;

  bfd_ram #(
    .WIDTH (8),
    .DEPTH (MAX_BODY),
    .AW    (AW)
  ) u_body_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (cnt_r[AW-1:0]),
    .wr_data (in_rx_byte),
    .rd_en   (ram_rd_en),
    .rd_addr (idx_r[AW-1:0]),
    .rd_data (ram_rd_data)
  );

  // handshake: input stalls during replay, and a byte that may give a result waits for room in the output register
  assign in_stall = (ctl_r != ST_RUN) ||
                    (out_valid_r && out_stall && (phase_r == PH_LEN || phase_r == PH_CHK));
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // helpers
  assign ph_eff    = in_chunk_start ? PH_SRC : phase_r;
  assign len_diff  = {1'b0, in_rx_byte} - 9'd2;
  assign len_err   = (in_rx_byte < 8'd2) || (len_diff > 9'(MAX_BODY));
  assign cnt_inc   = cnt_r + 1'b1;
  assign idx_inc   = idx_r + 1'b1;
  assign emit_last = (idx_inc == len_r);
  assign len_ext   = {6'd0, len_r};
  assign idx_ext   = {5'd0, idx_r};

  // sequencer next state
  always_comb begin
    ctl_nxt = ctl_r;
    case (ctl_r)
      ST_RUN: begin
        if (in_acc && ph_eff == PH_CHK && in_rx_byte == xor_r && len_r != '0) begin
          ctl_nxt = ST_RD;
        end
      end
      ST_RD: ctl_nxt = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          ctl_nxt = emit_last ? ST_RUN : ST_RD;
        end
      end
      default: ctl_nxt = ST_RUN;
    endcase
  end

  // sequencer outputs
  always_comb begin
    ram_rd_en = 1'b0;
    ram_wr_en = 1'b0;
    out_load  = 1'b0;
    case (ctl_r)
      ST_RUN: begin
        ram_wr_en = in_acc && ph_eff == PH_BODY;
        out_load  = in_acc && ((ph_eff == PH_LEN && len_err) ||
                    (ph_eff == PH_CHK && !(in_rx_byte == xor_r && len_r != '0)));
      end
      ST_RD:  ram_rd_en = 1'b1;
      ST_OUT: out_load  = out_free;
      default: ;
    endcase
  end

  // parser datapath and result formation
  always_comb begin
    phase_nxt      = phase_r;
    src_nxt        = src_r;
    dst_nxt        = dst_r;
    len_nxt        = len_r;
    cnt_nxt        = cnt_r;
    idx_nxt        = idx_r;
    xor_nxt        = xor_r;
    out_status_nxt = STAT_OK;
    out_src_nxt    = src_r;
    out_dst_nxt    = dst_r;
    out_len_nxt    = len_ext[5:0];
    out_byte_nxt   = 8'h00;
    out_idx_nxt    = 5'd0;
    out_last_nxt   = 1'b1;

    if (ctl_r == ST_RUN && in_acc) begin
      case (ph_eff)
        PH_SRC: begin
          src_nxt   = in_rx_byte;
          xor_nxt   = in_rx_byte;
          dst_nxt   = 8'h00;
          len_nxt   = '0;
          cnt_nxt   = '0;
          phase_nxt = PH_LEN;
        end
        PH_LEN: begin
          if (len_err) begin
            out_status_nxt = STAT_LEN;
            out_dst_nxt    = 8'h00;
            out_len_nxt    = 6'd0;
            phase_nxt      = PH_DISCARD;
          end else begin
            len_nxt   = len_diff[LEN_W-1:0];
            xor_nxt   = xor_r ^ in_rx_byte;
            phase_nxt = PH_DST;
          end
        end
        PH_DST: begin
          dst_nxt   = in_rx_byte;
          xor_nxt   = xor_r ^ in_rx_byte;
          cnt_nxt   = '0;
          phase_nxt = (len_r == '0) ? PH_CHK : PH_BODY;
        end
        PH_BODY: begin
          xor_nxt = xor_r ^ in_rx_byte;
          cnt_nxt = cnt_inc;
          if (cnt_inc >= len_r) begin
            phase_nxt = PH_CHK;
          end
        end
        PH_CHK: begin
          if (in_rx_byte != xor_r) begin
            out_status_nxt = STAT_CSUM;
          end
          idx_nxt   = '0;
          phase_nxt = PH_SRC;
        end
        default: ;
      endcase
    end else if (ctl_r == ST_OUT && out_free) begin
      // replay one body byte
      out_byte_nxt = ram_rd_data;
      out_idx_nxt  = idx_ext[4:0];
      out_last_nxt = emit_last;
      idx_nxt      = idx_inc;
    end

    // output register occupancy
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_SRC;
      ctl_r       <= ST_RUN;
      src_r       <= 8'h00;
      dst_r       <= 8'h00;
      len_r       <= '0;
      cnt_r       <= '0;
      idx_r       <= '0;
      xor_r       <= 8'h00;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      ctl_r       <= ctl_nxt;
      src_r       <= src_nxt;
      dst_r       <= dst_nxt;
      len_r       <= len_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      xor_r       <= xor_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // output payload, loaded only with a new request
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= out_status_nxt;
      out_src_r    <= out_src_nxt;
      out_dst_r    <= out_dst_nxt;
      out_len_r    <= out_len_nxt;
      out_byte_r   <= out_byte_nxt;
      out_idx_r    <= out_idx_nxt;
      out_last_r   <= out_last_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_source_addr = out_src_r;
  assign out_dest_addr   = out_dst_r;
  assign out_body_length = out_len_r;
  assign out_body_byte   = out_byte_r;
  assign out_byte_index  = out_idx_r;
  assign out_last        = out_last_r;

  // replay index stays inside the held body
  `ASSERT_IMP(a_idx_in_body, ctl_r != ST_RUN, idx_r < len_r, "replay index beyond body")
  // no new request is loaded over one that is still stalled
  `ASSERT_IMP(a_no_overwrite, out_valid_r && out_stall, !out_load, "output overwritten")
  // the final replayed byte hands control back to the receiver
  `ASSERT_NXT(a_last_ends, ctl_r == ST_OUT && out_free && emit_last, ctl_r == ST_RUN,
              "replay did not finish on last byte")
  // body writes happen only while receiving
  `ASSERT_IMP(a_wr_in_run, ram_wr_en, ctl_r == ST_RUN && !ram_rd_en, "body write during replay")

endmodule

[tb/sv/tb_bus_frame_deframer_xor_check_unit.sv]
// Self-checking testbench for bus_frame_deframer_xor_check_unit: directed frames, then
// random frame traffic checked against an in-bench deframer predictor.
// Depends on bfd_pkg and the deframer RTL only.
module tb_bus_frame_deframer_xor_check_unit
  import bfd_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int BODY_MAX = MAX_BODY_DEF;

  // One result request as it leaves the block
  typedef struct packed {
    logic [1:0] status;
    logic [7:0] src;
    logic [7:0] dst;
    logic [5:0] len;
    logic [7:0] data;
    logic [4:0] idx;
    logic       last;
  } report_t;

  // Directed stimulus row, optionally with a hand-written result
  typedef struct packed {
    logic [7:0] rx;
    logic       cs;
    logic       typed;
    report_t    res;
  } stim_row_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_rx_byte;
  logic       in_chunk_start;
  logic       out_valid;
  logic       out_stall;
  logic [1:0] out_status;
  logic [7:0] out_source_addr;
  logic [7:0] out_dest_addr;
  logic [5:0] out_body_length;
  logic [7:0] out_body_byte;
  logic [4:0] out_byte_index;
  logic       out_last;

  bus_frame_deframer_xor_check_unit u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_rx_byte      (in_rx_byte),
    .in_chunk_start  (in_chunk_start),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_source_addr (out_source_addr),
    .out_dest_addr   (out_dest_addr),
    .out_body_length (out_body_length),
    .out_body_byte   (out_body_byte),
    .out_byte_index  (out_byte_index),
    .out_last        (out_last)
  );

  // Predictor state, mirrors the parser
  phase_t     parse_ph;
  logic [7:0] frame_src;
  logic [7:0] frame_dst;
  int         frame_len;
  int         body_seen;
  logic [7:0] frame_xor;
  logic [7:0] body_copy [BODY_MAX];

  report_t reports_due [$];
  int      error_count;
  int      counted_items;
  int      send_idle_pct;
  int      recv_stall_pct;
  bit      hold_req;
  bit      need_start;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  initial begin
    #4_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Deframe one accepted byte; queues the reports it causes and returns their count
  function automatic int deframe_byte(input logic [7:0] b, input logic cs);
    int n;
    n = 0;
    if (cs || parse_ph != PH_DISCARD) counted_items++;
    if (cs) parse_ph = PH_SRC;
    case (parse_ph)
      PH_SRC: begin
        frame_src = b;
        frame_xor = b;
        frame_dst = 8'h00;
        frame_len = 0;
        body_seen = 0;
        parse_ph  = PH_LEN;
      end
      PH_LEN: begin
        if (b < 8'd2 || int'(b) - 2 > BODY_MAX) begin
          reports_due.push_back('{STAT_LEN, frame_src, 8'h00, 6'd0, 8'h00, 5'd0, 1'b1});
          n = 1;
          parse_ph = PH_DISCARD;
        end else begin
          frame_len = int'(b) - 2;
          frame_xor ^= b;
          parse_ph  = PH_DST;
        end
      end
      PH_DST: begin
        frame_dst = b;
        frame_xor ^= b;
        body_seen = 0;
        parse_ph  = (frame_len == 0) ? PH_CHK : PH_BODY;
      end
      PH_BODY: begin
        if (body_seen < BODY_MAX) body_copy[body_seen] = b;
        frame_xor ^= b;
        body_seen++;
        if (body_seen >= frame_len) parse_ph = PH_CHK;
      end
      PH_CHK: begin
        if (b != frame_xor) begin
          reports_due.push_back('{STAT_CSUM, frame_src, frame_dst, 6'(frame_len),
                                  8'h00, 5'd0, 1'b1});
          n = 1;
        end else if (frame_len == 0) begin
          reports_due.push_back('{STAT_OK, frame_src, frame_dst, 6'd0, 8'h00, 5'd0, 1'b1});
          n = 1;
        end else begin
          for (int i = 0; i < frame_len && i < BODY_MAX; i++) begin
            reports_due.push_back('{STAT_OK, frame_src, frame_dst, 6'(frame_len),
                                    body_copy[i], 5'(i), 1'(i + 1 == frame_len)});
            n++;
          end
        end
        parse_ph = PH_SRC;
      end
      default: ;  // dropping bytes until a chunk start
    endcase
    return n;
  endfunction

  // Offer one byte request, wait for acceptance, then predict
  task automatic send_byte(input logic [7:0] b, input logic cs, input logic use_typed,
                           input report_t typed);
    int n;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_rx_byte     <= b;
    in_chunk_start <= cs;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n = deframe_byte(b, cs);
    if (use_typed) begin
      repeat (n) void'(reports_due.pop_back());
      reports_due.push_back(typed);
    end
  endtask

  // Whole frame; cut > 0 abandons it after that many bytes
  task automatic send_frame(input logic cs, input logic [7:0] src, input int blen,
                            input int cut, input logic bad_sum);
    logic [7:0] frame_bytes [$];
    logic [7:0] sum;
    frame_bytes.push_back(src);
    frame_bytes.push_back(8'(blen + 2));
    frame_bytes.push_back(8'($urandom));
    repeat (blen) frame_bytes.push_back(8'($urandom));
    sum = 8'h00;
    foreach (frame_bytes[i]) sum ^= frame_bytes[i];
    if (bad_sum) sum ^= 8'($urandom_range(1, 255));
    frame_bytes.push_back(sum);
    if (cut > 0) while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
    foreach (frame_bytes[i]) send_byte(frame_bytes[i], (i == 0) ? cs : 1'b0, 1'b0, '0);
    need_start = (cut > 0);
  endtask

  // Mostly well-formed frames, with length and checksum errors, truncations and noise mixed in
  task automatic random_frame();
    int         kind;
    int         blen;
    logic       cs0;
    logic [7:0] lenb;
    kind = $urandom_range(99);
    cs0  = need_start ? 1'b1 : 1'($urandom_range(1));
    blen = ($urandom_range(9) == 0) ? $urandom_range(BODY_MAX) : $urandom_range(4);
    if (kind < 8) begin
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom), 1'($urandom_range(1)), 1'b0, '0);
      need_start = 1'b1;
    end else if (kind < 18) begin
      lenb = $urandom_range(1) ? 8'($urandom_range(1))
                               : 8'($urandom_range(BODY_MAX + 3, 255));
      send_byte(8'($urandom), cs0, 1'b0, '0);
      send_byte(lenb, 1'b0, 1'b0, '0);
      repeat ($urandom_range(3)) send_byte(8'($urandom), 1'b0, 1'b0, '0);
      need_start = 1'b1;
    end else if (kind < 86) begin
      send_frame(cs0, 8'($urandom), blen, 0, $urandom_range(99) < 15);
    end else begin
      send_frame(cs0, 8'($urandom), blen, $urandom_range(1, blen + 3), 1'b0);
    end
  endtask

  // Field comparison
  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      error_count++;
    end
  endtask

  // Result side: stall pattern plus one long hold-off on request
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Sampled mid-cycle, so outputs and predictor pushes have settled
  always @(negedge clk) begin : result_check
    report_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (reports_due.size() == 0) begin
        $error("result with nothing due: status %0d src 0x%0h", out_status, out_source_addr);
        error_count++;
      end else begin
        want = reports_due.pop_front();
        check_field("status", want.status, out_status);
        check_field("source_addr", want.src, out_source_addr);
        check_field("dest_addr", want.dst, out_dest_addr);
        check_field("body_length", want.len, out_body_length);
        check_field("body_byte", want.data, out_body_byte);
        check_field("byte_index", want.idx, out_byte_index);
        check_field("last", want.last, out_last);
      end
    end
  end

  // Main sequence
  initial begin : stimulus
    stim_row_t directed_bytes [26];
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_rx_byte     <= 8'h00;
    in_chunk_start <= 1'b0;
    error_count    = 0;
    counted_items  = 0;
    hold_req       = 1'b0;
    need_start     = 1'b1;
    send_idle_pct  = 24;
    recv_stall_pct = 68;
    parse_ph       = PH_SRC;
    frame_src      = 8'h00;
    frame_dst      = 8'h00;
    frame_len      = 0;
    body_seen      = 0;
    frame_xor      = 8'h00;

    directed_bytes = '{
      // first byte after reset is a source even without a start mark
      '{8'hFF, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b1, '{STAT_LEN, 8'hFF, 8'h00, 6'd0, 8'h00, 5'd0, 1'b1}},
      '{8'h55, 1'b0, 1'b0, '0},  // dropped
      // empty body, good checksum
      '{8'h00, 1'b1, 1'b0, '0},
      '{8'h02, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, '0},
      '{8'hFD, 1'b0, 1'b1, '{STAT_OK, 8'h00, 8'hFF, 6'd0, 8'h00, 5'd0, 1'b1}},
      // back to back, length byte one short
      '{8'hA5, 1'b0, 1'b0, '0},
      '{8'h01, 1'b0, 1'b1, '{STAT_LEN, 8'hA5, 8'h00, 6'd0, 8'h00, 5'd0, 1'b1}},
      // one body byte, checksum off by one bit
      '{8'h3C, 1'b1, 1'b0, '0},
      '{8'h03, 1'b0, 1'b0, '0},
      '{8'h81, 1'b0, 1'b0, '0},
      '{8'h7E, 1'b0, 1'b0, '0},
      '{8'hC1, 1'b0, 1'b1, '{STAT_CSUM, 8'h3C, 8'h81, 6'd1, 8'h00, 5'd0, 1'b1}},
      // body one over the store size
      '{8'h12, 1'b0, 1'b0, '0},
      '{8'h23, 1'b0, 1'b1, '{STAT_LEN, 8'h12, 8'h00, 6'd0, 8'h00, 5'd0, 1'b1}},
      // partial frame abandoned by a restart, then a good two-byte body
      '{8'h80, 1'b1, 1'b0, '0},
      '{8'h04, 1'b0, 1'b0, '0},
      '{8'h01, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'h99, 1'b1, 1'b0, '0},
      '{8'h04, 1'b0, 1'b0, '0},
      '{8'h02, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, '0},
      '{8'h01, 1'b0, 1'b0, '0},
      '{8'h61, 1'b0, 1'b0, '0}
    };

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_bytes[i])
      send_byte(directed_bytes[i].rx, directed_bytes[i].cs, directed_bytes[i].typed,
                directed_bytes[i].res);
    need_start = 1'b0;

    // Random traffic, slow receiver then slow sender
    while (counted_items < 145) random_frame();
    send_idle_pct  = 68;
    recv_stall_pct = 24;
    while (counted_items < 265) random_frame();

    // No idling; a long receiver hold-off backs the block up into its input
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req = 1'b1;
    send_frame(1'b1, 8'hC3, BODY_MAX, 0, 1'b0);
    send_frame(1'b0, 8'h5A, BODY_MAX, 0, 1'b0);
    send_frame(1'b0, 8'h0F, 0, 0, 1'b0);
    while (counted_items < 340) random_frame();
    in_valid <= 1'b0;

    // Drain, then a short quiet spell to catch stray results
    while (reports_due.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
